[rtl/mpr_pkg.sv]
// ---------------------------------------------------------------------------
// mpr_pkg
// shared types, constants and helpers of the masked pixel to rgb decoder
// ---------------------------------------------------------------------------
package mpr_pkg;

	// colormap geometry
	localparam int COLORMAP_DEPTH = 256;
	localparam int IDX_W          = $clog2(COLORMAP_DEPTH);

	// quotient bits of the scaling divider, one per stage
	localparam int DIV_STAGES = 16;

	// apb register map
	localparam int APB_ADDR_W = 5;
	localparam logic [2:0] REG_RED_MASK   = 3'd0;
	localparam logic [2:0] REG_GREEN_MASK = 3'd1;
	localparam logic [2:0] REG_BLUE_MASK  = 3'd2;
	localparam logic [2:0] REG_COLOR_CNT  = 3'd3;
	localparam logic [2:0] REG_CONV_MODE  = 3'd4;

	// request opcodes
	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_CONVERT = 1'b1;

	typedef enum logic [1:0] {
		MODE_DIRECT  = 2'd0,
		MODE_CHANNEL = 2'd1,
		MODE_INDEXED = 2'd2,
		MODE_SPARE   = 2'd3
	} mode_t;

	typedef struct packed {
		logic        opcode;
		logic [31:0] pixel_value;
		logic [7:0]  entry_index;
		logic [15:0] entry_red;
		logic [15:0] entry_green;
		logic [15:0] entry_blue;
	} req_t;

	typedef struct packed {
		logic [15:0] red_out;
		logic [15:0] green_out;
		logic [15:0] blue_out;
		logic [7:0]  index_out;
		logic        index_out_of_range;
	} rsp_t;

	// trailing-zero count, zero for an all-zero word
	function automatic logic [4:0] trail_zeros(input logic [31:0] w);
		logic [4:0] n;
		n = 5'd0;
		for (int i = 31; i >= 0; i--) begin
			if (w[i]) begin
				n = 5'(i);
			end
		end
		return n;
	endfunction

endpackage

[rtl/mpr_if.sv]
// ---------------------------------------------------------------------------
// mpr request and result channels
// valid / ready channels carrying one request or one result
// ---------------------------------------------------------------------------
interface mpr_req_if import mpr_pkg::*; ();
	logic valid;
	logic ready;
	req_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface mpr_rsp_if import mpr_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[rtl/masked_pixel_to_rgb_decoder.sv]
// ---------------------------------------------------------------------------
// masked_pixel_to_rgb_decoder
// extracts masked rgb fields from a pixel word and scales them to 16 bits,
// or looks them up in a loadable colormap
// ---------------------------------------------------------------------------
//
//  channel   dir   handshake               carries
//  req       in    valid / ready           colormap load or pixel convert
//  rsp       out   valid / ready           rgb result, index, range flag
//  apb       in    psel/penable/pready     masks, color count, mode
//
// one request enters per cycle while the pipe advances; a convert gives a
// result, a load gives none. the scaling divider has 16 restoring stages,
// one quotient bit each.
// reset clears the config and derived registers and all valid bits; the
// colormap is not cleared and holds garbage until loaded.
// the whole pipe advances together whenever the output register is empty
// or being taken, so a stall freezes every stage in place.
//
module masked_pixel_to_rgb_decoder import mpr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	mpr_req_if.sink               req,
	mpr_rsp_if.source             rsp,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	// ---------------- configuration registers ----------------
	logic [31:0] mask_q [3];
	logic [8:0]  color_count_q;
	logic [1:0]  mode_q;

	logic        cfg_wr;
	logic [2:0]  cfg_sel;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_sel = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q[0]     <= '0;
			mask_q[1]     <= '0;
			mask_q[2]     <= '0;
			color_count_q <= '0;
			mode_q        <= '0;
		end else if (cfg_wr) begin
			case (cfg_sel)
				REG_RED_MASK:   mask_q[0] <= pwdata;
				REG_GREEN_MASK: mask_q[1] <= pwdata;
				REG_BLUE_MASK:  mask_q[2] <= pwdata;
				REG_COLOR_CNT:  color_count_q <= pwdata[8:0];
				REG_CONV_MODE:  mode_q <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_sel)
			REG_RED_MASK:   prdata = mask_q[0];
			REG_GREEN_MASK: prdata = mask_q[1];
			REG_BLUE_MASK:  prdata = mask_q[2];
			REG_COLOR_CNT:  prdata = 32'(color_count_q);
			REG_CONV_MODE:  prdata = 32'(mode_q);
			default:        prdata = '0;
		endcase
	end

	// derived from config: shift, right-aligned mask, saturated color count
	logic [4:0]  shift_q [3];
	logic [31:0] algn_q [3];
	logic [31:0] limit_q;
	logic [31:0] cc_ext;

	assign cc_ext = 32'(color_count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 3; c++) begin
				shift_q[c] <= '0;
				algn_q[c]  <= '0;
			end
			limit_q <= '0;
		end else begin
			for (int c = 0; c < 3; c++) begin
				shift_q[c] <= trail_zeros(mask_q[c]);
				algn_q[c]  <= mask_q[c] >> trail_zeros(mask_q[c]);
			end
			limit_q <= (cc_ext > 32'(COLORMAP_DEPTH)) ? 32'(COLORMAP_DEPTH) : cc_ext;
		end
	end

	// ---------------- global pipe advance ----------------
	logic out_v_q;
	logic adv;

	assign adv       = !out_v_q || rsp.ready;
	assign req.ready = adv;

	// ---------------- stage 1: request capture ----------------
	logic v_s1;
	req_t pl_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pl_s1 <= req.payload;
		end
	end

	// field extraction and colormap index checks
	logic [31:0]      fld [3];
	logic             fld_bad [3];
	logic [IDX_W-1:0] fld_addr [3];
	logic             pix_bad;
	logic [31:0]      pix_idx;
	mode_t            mode_cur;

	assign mode_cur = mode_t'(mode_q);

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			fld[c]      = (pl_s1.pixel_value >> shift_q[c]) & algn_q[c];
			fld_bad[c]  = fld[c] >= limit_q;
			fld_addr[c] = fld_bad[c] ? '0 : fld[c][IDX_W-1:0];
		end
		pix_bad = pl_s1.pixel_value >= limit_q;
		pix_idx = pix_bad ? '0 : pl_s1.pixel_value;
	end

	// ---------------- stage 2: colormap access ----------------
	logic             v_s2;
	logic             load_s2;
	logic             direct_s2;
	logic [31:0]      fld_s2 [3];
	logic [IDX_W-1:0] addr_s2 [3];
	logic             bad_s2;
	logic [7:0]       idx_s2;
	logic             wr_ok_s2;
	logic [IDX_W-1:0] waddr_s2;
	logic [15:0]      wdat_s2 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			load_s2  <= pl_s1.opcode == OP_LOAD;
			fld_s2   <= fld;
			wr_ok_s2 <= 32'(pl_s1.entry_index) < 32'(COLORMAP_DEPTH);
			waddr_s2 <= IDX_W'(pl_s1.entry_index);
			wdat_s2[0] <= pl_s1.entry_red;
			wdat_s2[1] <= pl_s1.entry_green;
			wdat_s2[2] <= pl_s1.entry_blue;
			case (mode_cur)
				MODE_CHANNEL: begin
					direct_s2 <= 1'b0;
					addr_s2   <= fld_addr;
					bad_s2    <= fld_bad[0] || fld_bad[1] || fld_bad[2];
					idx_s2    <= '0;
				end
				MODE_INDEXED: begin
					direct_s2  <= 1'b0;
					addr_s2[0] <= pix_idx[IDX_W-1:0];
					addr_s2[1] <= pix_idx[IDX_W-1:0];
					addr_s2[2] <= pix_idx[IDX_W-1:0];
					bad_s2     <= pix_bad;
					idx_s2     <= pix_idx[7:0];
				end
				default: begin
					// direct scaling, also taken by the spare mode code
					direct_s2 <= 1'b1;
					addr_s2   <= fld_addr;
					bad_s2    <= 1'b0;
					idx_s2    <= '0;
				end
			endcase
		end
	end

	// one memory per component so each channel reads at its own address
	logic [15:0] map_r [COLORMAP_DEPTH];
	logic [15:0] map_g [COLORMAP_DEPTH];
	logic [15:0] map_b [COLORMAP_DEPTH];
	logic        map_we;

	assign map_we = adv && v_s2 && load_s2 && wr_ok_s2;

	// pipe arrays: index 0 is stage 3, index i+1 follows divider step i
	logic        v_d      [DIV_STAGES+1];
	logic        direct_d [DIV_STAGES+1];
	logic        bad_d    [DIV_STAGES+1];
	logic [7:0]  idx_d    [DIV_STAGES+1];
	logic [15:0] rd_d     [DIV_STAGES+1][3];
	logic [31:0] rem_d    [DIV_STAGES+1][3];
	logic [15:0] low_d    [DIV_STAGES+1][3];
	logic [15:0] quo_d    [DIV_STAGES+1][3];

	always_ff @(posedge clk) begin
		if (map_we) begin
			map_r[waddr_s2] <= wdat_s2[0];
			map_g[waddr_s2] <= wdat_s2[1];
			map_b[waddr_s2] <= wdat_s2[2];
		end
		if (adv) begin
			rd_d[0][0] <= map_r[addr_s2[0]];
			rd_d[0][1] <= map_g[addr_s2[1]];
			rd_d[0][2] <= map_b[addr_s2[2]];
		end
	end

	// field * 65535 as (field << 16) - field; top 32 bits seed the remainder
	logic [47:0] num [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			num[c] = {fld_s2[c], 16'h0000} - 48'(fld_s2[c]);
		end
	end

	// ---------------- stage 3: divider setup ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_d[0] <= 1'b0;
		end else if (adv) begin
			// loads end here
			v_d[0] <= v_s2 && !load_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			direct_d[0] <= direct_s2;
			bad_d[0]    <= bad_s2;
			idx_d[0]    <= idx_s2;
			for (int c = 0; c < 3; c++) begin
				rem_d[0][c] <= num[c][47:16];
				low_d[0][c] <= num[c][15:0];
				quo_d[0][c] <= '0;
			end
		end
	end

	// ---------------- restoring divider, one quotient bit per stage ----------------
	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
		logic [32:0] trial [3];
		logic        take [3];

		always_comb begin
			for (int c = 0; c < 3; c++) begin
				trial[c] = {rem_d[i][c], low_d[i][c][15]};
				take[c]  = trial[c] >= {1'b0, algn_q[c]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_d[i+1] <= 1'b0;
			end else if (adv) begin
				v_d[i+1] <= v_d[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				direct_d[i+1] <= direct_d[i];
				bad_d[i+1]    <= bad_d[i];
				idx_d[i+1]    <= idx_d[i];
				rd_d[i+1]     <= rd_d[i];
				for (int c = 0; c < 3; c++) begin
					rem_d[i+1][c] <= take[c] ? 32'(trial[c] - {1'b0, algn_q[c]})
								: trial[c][31:0];
					low_d[i+1][c] <= {low_d[i][c][14:0], 1'b0};
					quo_d[i+1][c] <= {quo_d[i][c][14:0], take[c]};
				end
			end
		end
	end

	// ---------------- output register ----------------
	logic [15:0] res [3];
	rsp_t        out_q;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			if (!direct_d[DIV_STAGES]) begin
				res[c] = rd_d[DIV_STAGES][c];
			end else if (algn_q[c] == '0) begin
				// empty mask scales to zero
				res[c] = '0;
			end else begin
				res[c] = quo_d[DIV_STAGES][c];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= v_d[DIV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.red_out            <= res[0];
			out_q.green_out          <= res[1];
			out_q.blue_out           <= res[2];
			out_q.index_out          <= idx_d[DIV_STAGES];
			out_q.index_out_of_range <= bad_d[DIV_STAGES];
		end
	end

	assign rsp.valid   = out_v_q;
	assign rsp.payload = out_q;

endmodule

[tb/mpr_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mpr_checker
// watches the request, result and apb ports of the decoder, keeps its own
// copy of the registers and colormap, predicts each convert result and
// compares it field by field with what the block hands out
// ---------------------------------------------------------------------------
module mpr_checker import mpr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	mpr_req_if                    req,
	mpr_rsp_if                    rsp,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	input  logic                  pready,
	output int                    fail_count,
	output int                    pending
);

	logic [31:0] exp_rmask, exp_gmask, exp_bmask;
	logic [8:0]  color_limit;
	mode_t       mode;
	logic [15:0] map_r [COLORMAP_DEPTH];
	logic [15:0] map_g [COLORMAP_DEPTH];
	logic [15:0] map_b [COLORMAP_DEPTH];
	rsp_t        rgb_expected [$];

	// field under the mask, moved down to bit 0; aligned gets the shifted mask
	function automatic logic [31:0] masked_field(input logic [31:0] pix,
			input logic [31:0] mask, output logic [31:0] aligned);
		logic [31:0] m;
		logic [31:0] p;
		m = mask;
		p = pix;
		while (m != 0 && !m[0]) begin
			m = m >> 1;
			p = p >> 1;
		end
		aligned = m;
		return p & m;
	endfunction

	function automatic logic [15:0] scaled_field(input logic [31:0] pix,
			input logic [31:0] mask);
		logic [31:0] aligned;
		logic [63:0] f;
		f = 64'(masked_field(pix, mask, aligned));
		if (aligned == 0) return 16'd0;
		return 16'((f * 64'd65535) / 64'(aligned));
	endfunction

	// out-of-range index falls back to entry 0 and raises the flag
	function automatic int clamp_index(input logic [31:0] idx, inout logic bad);
		int lim;
		lim = (color_limit > COLORMAP_DEPTH) ? COLORMAP_DEPTH : int'(color_limit);
		if (64'(idx) < 64'(lim)) return int'(idx);
		bad = 1'b1;
		return 0;
	endfunction

	function automatic rsp_t decode_pixel(input logic [31:0] pix);
		rsp_t o;
		logic [31:0] aligned;
		int k;
		o = '0;
		case (mode)
			MODE_CHANNEL: begin
				k = clamp_index(masked_field(pix, exp_rmask, aligned), o.index_out_of_range);
				o.red_out = map_r[k];
				k = clamp_index(masked_field(pix, exp_gmask, aligned), o.index_out_of_range);
				o.green_out = map_g[k];
				k = clamp_index(masked_field(pix, exp_bmask, aligned), o.index_out_of_range);
				o.blue_out = map_b[k];
			end
			MODE_INDEXED: begin
				k = clamp_index(pix, o.index_out_of_range);
				o.red_out = map_r[k];
				o.green_out = map_g[k];
				o.blue_out = map_b[k];
				o.index_out = 8'(k);
			end
			default: begin
				o.red_out = scaled_field(pix, exp_rmask);
				o.green_out = scaled_field(pix, exp_gmask);
				o.blue_out = scaled_field(pix, exp_bmask);
			end
		endcase
		return o;
	endfunction

	assign pending = rgb_expected.size();

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			exp_rmask <= '0;
			exp_gmask <= '0;
			exp_bmask <= '0;
			color_limit <= '0;
			mode <= MODE_DIRECT;
			fail_count <= 0;
			rgb_expected.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_RED_MASK:   exp_rmask <= pwdata;
					REG_GREEN_MASK: exp_gmask <= pwdata;
					REG_BLUE_MASK:  exp_bmask <= pwdata;
					REG_COLOR_CNT:  color_limit <= pwdata[8:0];
					REG_CONV_MODE:  mode <= mode_t'(pwdata[1:0]);
					default: ;
				endcase
			end
			if (req.valid && req.ready) begin
				if (req.payload.opcode == OP_LOAD) begin
					map_r[req.payload.entry_index] <= req.payload.entry_red;
					map_g[req.payload.entry_index] <= req.payload.entry_green;
					map_b[req.payload.entry_index] <= req.payload.entry_blue;
				end else begin
					rgb_expected.push_back(decode_pixel(req.payload.pixel_value));
				end
			end
			if (rsp.valid && rsp.ready) begin
				if (rgb_expected.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: unexpected result %h", $realtime, rsp.payload);
					fail_count <= fail_count + 1;
				end else begin
					want = rgb_expected.pop_front();
					if (rsp.payload !== want) begin
						if (fail_count < 10)
							$display("%0t: mismatch exp r%h g%h b%h i%h f%b got r%h g%h b%h i%h f%b",
								$realtime, want.red_out, want.green_out, want.blue_out,
								want.index_out, want.index_out_of_range,
								rsp.payload.red_out, rsp.payload.green_out,
								rsp.payload.blue_out, rsp.payload.index_out,
								rsp.payload.index_out_of_range);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// drives colormap loads and pixel converts through the decoder across all
// conversion modes and a range of masks and color counts, with random gaps
// and stalls; the checker beside the block predicts and compares
// ---------------------------------------------------------------------------
module tb_top;
	import mpr_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [31:0]           pwdata;
	logic [31:0]           prdata;
	logic                  pready;
	int                    fail_count;
	int                    pending;

	// no gaps on either side while set
	bit                    burst;
	// asks the result side for one long hold-off
	bit                    hold_req;

	mpr_req_if req_if ();
	mpr_rsp_if rsp_if ();

	masked_pixel_to_rgb_decoder dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_if),
		.rsp     (rsp_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	mpr_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_if),
		.rsp        (rsp_if),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// hard stop well beyond the slowest legal run
	initial begin
		#3ms;
		$display("tb_top failed");
		$finish;
	end

	// result side: random stalls per result, one long hold-off on request
	initial begin
		int stall;
		stall = 0;
		rsp_if.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				// long hold-off so the pipe fills and the request side stalls
				hold_req = 1'b0;
				rsp_if.ready <= 1'b0;
				repeat (300) @(posedge clk);
			end else if (rsp_if.valid && rsp_if.ready) begin
				stall = burst ? 0 : $urandom_range(0, 4);
				rsp_if.ready <= (stall == 0);
			end else if (stall > 0) begin
				stall--;
				rsp_if.ready <= (stall == 0);
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end
	end

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_ADDR_W'({idx, 2'b00});
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// valid stays high between back-to-back requests
	task automatic send(input req_t r);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.payload <= r;
		do @(posedge clk); while (!req_if.ready);
	endtask

	task automatic load_entry(input logic [7:0] idx, input logic [15:0] r,
			input logic [15:0] g, input logic [15:0] b);
		req_t q;
		q = '0;
		q.opcode = OP_LOAD;
		q.pixel_value = $urandom;
		q.entry_index = idx;
		q.entry_red = r;
		q.entry_green = g;
		q.entry_blue = b;
		send(q);
	endtask

	task automatic convert(input logic [31:0] pix);
		req_t q;
		q.opcode = OP_CONVERT;
		q.pixel_value = pix;
		q.entry_index = 8'($urandom);
		q.entry_red = 16'($urandom);
		q.entry_green = 16'($urandom);
		q.entry_blue = 16'($urandom);
		send(q);
	endtask

	// wait for all results, then let the pipe run dry
	task automatic drain();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic configure(input logic [31:0] rm, input logic [31:0] gm,
			input logic [31:0] bm, input logic [8:0] cnt, input mode_t m);
		drain();
		reg_write(REG_RED_MASK, rm);
		reg_write(REG_GREEN_MASK, gm);
		reg_write(REG_BLUE_MASK, bm);
		reg_write(REG_COLOR_CNT, 32'(cnt));
		reg_write(REG_CONV_MODE, 32'(m));
	endtask

	// mostly a contiguous field, sometimes an arbitrary word
	function automatic logic [31:0] some_mask();
		int w;
		int pos;
		if ($urandom_range(0, 5) == 0) return $urandom;
		w = $urandom_range(1, 12);
		pos = $urandom_range(0, 32 - w);
		return ((32'd1 << w) - 32'd1) << pos;
	endfunction

	// random mix of loads and converts; indexed mode favors small pixels
	task automatic random_mix(input int n, input bit small_pix);
		logic [31:0] pix;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 3) == 0) begin
				load_entry(8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
			end else begin
				pix = $urandom;
				if (small_pix && $urandom_range(0, 3) != 0) pix = $urandom_range(0, 300);
				convert(pix);
			end
		end
	endtask

	initial begin
		mode_t m;
		req_if.valid <= 1'b0;
		req_if.payload <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		burst = 1'b0;
		hold_req = 1'b0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill the whole colormap so no lookup ever hits an unwritten entry
		load_entry(8'd0, 16'h0000, 16'h0000, 16'h0000);
		for (int i = 1; i < 255; i++)
			load_entry(8'(i), 16'($urandom), 16'($urandom), 16'($urandom));
		load_entry(8'd255, 16'hffff, 16'hffff, 16'hffff);

		// zero masks after reset: every channel reads 0
		convert(32'h0000_0000);
		convert(32'hffff_ffff);

		// byte fields, direct scaling
		configure(32'h00ff_0000, 32'h0000_ff00, 32'h0000_00ff, 9'd256, MODE_DIRECT);
		convert(32'h0000_0000);
		convert(32'hffff_ffff);
		convert(32'h0080_4020);

		// widest, top-bit and bottom-bit masks
		configure(32'hffff_ffff, 32'h8000_0000, 32'h0000_0001, 9'd0, MODE_DIRECT);
		convert(32'hffff_ffff);
		convert(32'h8000_0001);
		convert(32'h7fff_fffe);

		// unused mode behaves as direct
		configure(32'h0000_f800, 32'h0000_07e0, 32'h0000_001f, 9'd256, MODE_SPARE);
		convert(32'h0000_ffff);
		convert(32'h0000_a5a5);

		// fields index the colormap; 9-bit red field can overflow the count
		configure(32'h0001_ff00, 32'h0000_00f0, 32'h0000_000f, 9'd256, MODE_CHANNEL);
		convert(32'h0001_ff00);
		convert(32'h0000_ffff);
		configure(32'h0001_ff00, 32'h0000_00f0, 32'h0000_000f, 9'd0, MODE_CHANNEL);
		convert(32'h0000_1234);

		// whole pixel as index, at and beyond the count
		configure(32'h0, 32'h0, 32'h0, 9'd256, MODE_INDEXED);
		convert(32'd0);
		convert(32'd255);
		convert(32'd256);
		convert(32'hffff_ffff);
		configure(32'h0, 32'h0, 32'h0, 9'd37, MODE_INDEXED);
		convert(32'd36);
		convert(32'd37);

		// random phases over random settings
		for (int ph = 0; ph < 8; ph++) begin
			m = mode_t'($urandom_range(0, 3));
			configure(some_mask(), some_mask(), some_mask(),
				9'($urandom_range(0, 256)), m);
			burst = ($urandom_range(0, 3) == 0);
			if (ph == 2) hold_req = 1'b1;
			random_mix(17, m == MODE_INDEXED);
			// one pause on the request side until everything has come back
			if (ph == 4) drain();
			random_mix(17, m == MODE_INDEXED);
		end
		burst = 1'b0;

		drain();
		if (fail_count == 0 && pending == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/mpr_pkg.sv
rtl/mpr_if.sv
rtl/masked_pixel_to_rgb_decoder.sv
tb/mpr_checker.sv
tb/tb_top.sv
